>>> design/telnet_receive_parser_top_defines.svh
// Assertion macros for the telnet receive parser checker.
// Included by the checker file only; no other dependencies.
`ifndef TELNET_RECEIVE_PARSER_TOP_DEFINES_SVH
`define TELNET_RECEIVE_PARSER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define TRP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("telnet parser check failed");
// Implication checked on the edge after the antecedent
`define TRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("telnet parser check failed");
`endif

>>> design/trp_pkg.sv
// Shared types and constants for the telnet receive parser.
// No dependencies.
package trp_pkg;
  localparam int EscDepth = 32;
  localparam int EscAw = 5;
  localparam logic [12:0] SubMax = 13'd4096;

  localparam logic [7:0] B_IAC = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB = 8'd250;
  localparam logic [7:0] B_SE = 8'd240;
  localparam logic [7:0] B_ESC = 8'd27;
  localparam logic [7:0] B_CR = 8'd13;
  localparam logic [7:0] CH_M = 8'h6d;
  localparam logic [7:0] CH_Z = 8'h7a;

  localparam logic [7:0] OPT_ECHO = 8'd1;
  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] OPT_EOR = 8'd25;
  localparam logic [7:0] OPT_NAWS = 8'd31;
  localparam logic [7:0] OPT_MCCP1 = 8'd85;
  localparam logic [7:0] OPT_MCCP2 = 8'd86;
  localparam logic [7:0] OPT_MSP = 8'd90;
  localparam logic [7:0] OPT_MXP = 8'd91;
  localparam logic [7:0] OPT_ZMP = 8'd93;

  localparam logic [1:0] CH_USER = 2'd0;
  localparam logic [1:0] CH_REPLY = 2'd1;
  localparam logic [1:0] CH_EVENT = 2'd2;

  localparam logic [3:0] EV_NONE = 4'd0;
  localparam logic [3:0] EV_ECHO_ON = 4'd1;
  localparam logic [3:0] EV_ECHO_OFF = 4'd2;
  localparam logic [3:0] EV_MXP = 4'd3;
  localparam logic [3:0] EV_MSP = 4'd4;
  localparam logic [3:0] EV_ZMP = 4'd5;
  localparam logic [3:0] EV_MCCP1 = 4'd6;
  localparam logic [3:0] EV_MCCP2 = 4'd7;
  localparam logic [3:0] EV_EOR = 4'd8;
  localparam logic [3:0] EV_NAWS = 4'd9;
  localparam logic [3:0] EV_COMPRESS = 4'd10;
  localparam logic [3:0] EV_ZMP_MSG = 4'd11;
  localparam logic [3:0] EV_TTYPE = 4'd12;
  localparam logic [3:0] EV_OVERFLOW = 4'd13;

  localparam logic [1:0] CFG_WIDTH = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  // Reply burst list: up to 16 scripted words (full window size report) plus one event
  localparam int ScrDepth = 17;
  localparam int ScrAw = 5;

  typedef struct packed {
    logic [1:0] chan;
    logic [7:0] data;
    logic [3:0] ev;
    logic       last;
  } res_t;
endpackage

>>> design/trp_esc_ram.sv
// Escape sequence buffer: synchronous RAM, one write and one read port.
// Depends on trp_pkg.
module trp_esc_ram (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [trp_pkg::EscAw-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic [trp_pkg::EscAw-1:0] rd_addr,
  output logic [7:0]               rd_data
);
  logic [7:0] mem [trp_pkg::EscDepth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

>>> design/trp_out_reg.sv
// Output register stage: holds one result word toward the sink.
// Depends on trp_pkg.
module trp_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  trp_pkg::res_t   push_word,
  output logic            free,
  output logic            out_tvalid,
  input  logic            out_tready,
  output trp_pkg::res_t   out_word
);
  logic valid_r;
  trp_pkg::res_t word_r;

  assign free = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_word = word_r;

  // Load on push, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
    if (push) begin
      word_r <= push_word;
    end
  end
endmodule

>>> design/telnet_receive_parser_top.sv
// Telnet receive parser: takes one received byte per word, walks the telnet
// state machine and emits user bytes, reply bytes and events. Depends on trp_pkg,
// trp_esc_ram and trp_out_reg.
//
// Flow: a byte that gives at most one result is taken and its word pushed in
// the same cycle. A byte that gives a burst of result words is decoded into the
// burst list when it is taken, and its words are then pushed in turn; a passed
// escape sequence of n buffered bytes gives n+1 words, read from the escape
// buffer RAM one byte ahead. A word that the sink does not take holds the flow.
// One byte is in work at a time; the next byte is taken only when the output
// register is empty or being emptied.
// No clearing pass is needed after reset.
module telnet_receive_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [11:8] event_code, [15:12] zero
  output logic [1:0]  out_tuser,  // [1:0] out_channel
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  typedef enum logic [3:0] {
    P_NORMAL, P_IAC, P_WILL, P_WONT, P_DO, P_DONT, P_SB, P_SBIAC, P_ANSI
  } pst_t;
  typedef enum logic [1:0] {M_IDLE, M_SCRIPT, M_ESCRD} mode_t;

  pst_t  pst_r;
  mode_t mode_r;
  logic [5:0]  esc_cnt_r;
  logic [7:0]  sub_opt_r, sub_sec_r;
  logic [12:0] sub_len_r;
  logic [1:0]  comp_r;
  logic        sound_r, echo_r, naws_r;
  logic [15:0] win_w_r, win_h_r;

  // Reply burst list and escape playback
  trp_pkg::res_t scr_r [trp_pkg::ScrDepth];
  logic [trp_pkg::ScrAw-1:0] scr_n_r, scr_i_r;
  logic [5:0] rd_i_r;
  logic [7:0] fin_r;
  logic       rd_pend_r;

  logic       free, push;
  trp_pkg::res_t push_word, ow;
  logic [7:0] ram_q, b;
  logic       acc, ram_we;
  logic [trp_pkg::EscAw-1:0] ram_wa, ram_ra;

  assign b = in_tdata;
  assign in_tready = (mode_r == M_IDLE) && free;
  assign acc = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  trp_esc_ram u_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(b),
    .rd_addr(ram_ra), .rd_data(ram_q)
  );

  trp_out_reg u_out (
    .clk(clk), .rst_n(rst_n), .push(push), .push_word(push_word), .free(free),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_word(ow)
  );

  assign out_tdata = {4'd0, ow.ev, ow.data};
  assign out_tuser = ow.chan;
  assign out_tlast = ow.last;

  // Per-byte decode into a burst list
  trp_pkg::res_t lst [trp_pkg::ScrDepth];
  logic [trp_pkg::ScrAw:0] ln;
  pst_t  pst_nxt;
  logic [5:0]  esc_cnt_nxt;
  logic [7:0]  sub_opt_nxt, sub_sec_nxt;
  logic [12:0] sub_len_nxt;
  logic [1:0]  comp_nxt;
  logic        sound_nxt, echo_nxt, naws_nxt, play;
  logic        alpha;

  function automatic trp_pkg::res_t mk(input logic [1:0] c, input logic [7:0] d,
                                       input logic [3:0] e);
    trp_pkg::res_t r;
    r.chan = c; r.data = d; r.ev = e; r.last = 1'b0;
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < trp_pkg::ScrDepth; k++) begin
      lst[k] = mk(trp_pkg::CH_USER, 8'd0, trp_pkg::EV_NONE);
    end
    ln = '0;
    pst_nxt = pst_r; esc_cnt_nxt = esc_cnt_r;
    sub_opt_nxt = sub_opt_r; sub_sec_nxt = sub_sec_r; sub_len_nxt = sub_len_r;
    comp_nxt = comp_r; sound_nxt = sound_r; echo_nxt = echo_r; naws_nxt = naws_r;
    play = 1'b0; ram_we = 1'b0; ram_wa = esc_cnt_r[trp_pkg::EscAw-1:0];
    alpha = (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
    case (pst_r)
      P_IAC: begin
        pst_nxt = P_NORMAL;
        if (b == trp_pkg::B_IAC) begin
          lst[0] = mk(trp_pkg::CH_USER, trp_pkg::B_IAC, trp_pkg::EV_NONE); ln = 6'd1;
        end else if (b == trp_pkg::B_WILL) pst_nxt = P_WILL;
        else if (b == trp_pkg::B_WONT) pst_nxt = P_WONT;
        else if (b == trp_pkg::B_DO) pst_nxt = P_DO;
        else if (b == trp_pkg::B_DONT) pst_nxt = P_DONT;
        else if (b == trp_pkg::B_SB) pst_nxt = P_SB;
      end
      P_WILL: begin
        pst_nxt = P_NORMAL;
        lst[0] = mk(trp_pkg::CH_REPLY, trp_pkg::B_IAC, trp_pkg::EV_NONE);
        lst[1] = mk(trp_pkg::CH_REPLY, trp_pkg::B_DO, trp_pkg::EV_NONE);
        lst[2] = mk(trp_pkg::CH_REPLY, b, trp_pkg::EV_NONE);
        lst[3] = mk(trp_pkg::CH_EVENT, 8'd0, trp_pkg::EV_NONE);
        ln = 6'd4;
        case (b)
          trp_pkg::OPT_MCCP2: begin
            if (comp_r == 2'd0) begin comp_nxt = 2'd2; lst[3].ev = trp_pkg::EV_MCCP2; end
            else ln = 6'd0;
          end
          trp_pkg::OPT_MCCP1: begin
            if (comp_r == 2'd0) begin comp_nxt = 2'd1; lst[3].ev = trp_pkg::EV_MCCP1; end
            else ln = 6'd0;
          end
          trp_pkg::OPT_EOR: lst[3].ev = trp_pkg::EV_EOR;
          trp_pkg::OPT_MSP: begin
            if (!sound_r) begin sound_nxt = 1'b1; lst[3].ev = trp_pkg::EV_MSP; end
            else ln = 6'd0;
          end
          trp_pkg::OPT_MXP: lst[3].ev = trp_pkg::EV_MXP;
          trp_pkg::OPT_ZMP: lst[3].ev = trp_pkg::EV_ZMP;
          trp_pkg::OPT_ECHO: begin echo_nxt = 1'b1; lst[3].ev = trp_pkg::EV_ECHO_ON; end
          default: begin
            lst[1].data = trp_pkg::B_DONT;
            ln = 6'd3;
            if (b == trp_pkg::B_IAC) begin lst[3] = lst[2]; ln = 6'd4; end
          end
        endcase
      end
      P_WONT: begin
        pst_nxt = P_NORMAL;
        if (b == trp_pkg::OPT_ECHO) begin
          lst[0] = mk(trp_pkg::CH_REPLY, trp_pkg::B_IAC, trp_pkg::EV_NONE);
          lst[1] = mk(trp_pkg::CH_REPLY, trp_pkg::B_DONT, trp_pkg::EV_NONE);
          lst[2] = mk(trp_pkg::CH_REPLY, b, trp_pkg::EV_NONE);
          lst[3] = mk(trp_pkg::CH_EVENT, 8'd0, trp_pkg::EV_ECHO_OFF);
          ln = 6'd4; echo_nxt = 1'b0;
        end
      end
      P_DO: begin
        pst_nxt = P_NORMAL;
        lst[0] = mk(trp_pkg::CH_REPLY, trp_pkg::B_IAC, trp_pkg::EV_NONE);
        lst[1] = mk(trp_pkg::CH_REPLY, trp_pkg::B_WILL, trp_pkg::EV_NONE);
        lst[2] = mk(trp_pkg::CH_REPLY, b, trp_pkg::EV_NONE);
        if (b == trp_pkg::OPT_NAWS) begin
          if (!naws_r) begin
            naws_nxt = 1'b1;
            lst[3] = mk(trp_pkg::CH_REPLY, trp_pkg::B_IAC, trp_pkg::EV_NONE);
            lst[4] = mk(trp_pkg::CH_REPLY, trp_pkg::B_SB, trp_pkg::EV_NONE);
            lst[5] = mk(trp_pkg::CH_REPLY, trp_pkg::OPT_NAWS, trp_pkg::EV_NONE);
            ln = 6'd6;
            for (int k = 0; k < 4; k++) begin
              logic [7:0] v;
              v = (k == 0) ? win_w_r[15:8] : (k == 1) ? win_w_r[7:0] :
                  (k == 2) ? win_h_r[15:8] : win_h_r[7:0];
              lst[ln[trp_pkg::ScrAw-1:0]] = mk(trp_pkg::CH_REPLY, v, trp_pkg::EV_NONE);
              ln = ln + 1'b1;
              if (v == trp_pkg::B_IAC) begin
                lst[ln[trp_pkg::ScrAw-1:0]] = mk(trp_pkg::CH_REPLY, v, trp_pkg::EV_NONE);
                ln = ln + 1'b1;
              end
            end
            lst[ln[trp_pkg::ScrAw-1:0]] =
              mk(trp_pkg::CH_REPLY, trp_pkg::B_IAC, trp_pkg::EV_NONE);
            ln = ln + 1'b1;
            lst[ln[trp_pkg::ScrAw-1:0]] =
              mk(trp_pkg::CH_REPLY, trp_pkg::B_SE, trp_pkg::EV_NONE);
            ln = ln + 1'b1;
            lst[ln[trp_pkg::ScrAw-1:0]] = mk(trp_pkg::CH_EVENT, 8'd0, trp_pkg::EV_NAWS);
            ln = ln + 1'b1;
          end
        end else if (b == trp_pkg::OPT_MXP) begin
          lst[3] = mk(trp_pkg::CH_EVENT, 8'd0, trp_pkg::EV_MXP);
          ln = 6'd4;
        end else begin
          lst[1].data = trp_pkg::B_WONT;
          ln = 6'd3;
          if (b == trp_pkg::B_IAC) begin lst[3] = lst[2]; ln = 6'd4; end
        end
      end
      P_DONT: pst_nxt = P_NORMAL;
      P_SB, P_SBIAC: begin
        logic fin, store;
        logic [7:0] sv;
        fin = 1'b0; store = 1'b0; sv = b;
        if (pst_r == P_SB) begin
          if (b == trp_pkg::B_IAC) pst_nxt = P_SBIAC;
          else if (b == trp_pkg::B_SE && sub_len_r == 13'd2 &&
                   sub_opt_r == trp_pkg::OPT_MCCP1 && sub_sec_r == trp_pkg::B_WILL) fin = 1'b1;
          else store = 1'b1;
        end else if (b == trp_pkg::B_SE) begin
          fin = 1'b1;
        end else begin
          store = 1'b1; sv = trp_pkg::B_IAC; pst_nxt = P_SB;
        end
        if (store) begin
          if (sub_len_r >= trp_pkg::SubMax) begin
            lst[0] = mk(trp_pkg::CH_EVENT, 8'd0, trp_pkg::EV_OVERFLOW); ln = 6'd1;
          end else begin
            if (sub_len_r == 13'd0) sub_opt_nxt = sv;
            else if (sub_len_r == 13'd1) sub_sec_nxt = sv;
            sub_len_nxt = sub_len_r + 13'd1;
          end
        end
        if (fin) begin
          if (sub_len_r != 13'd0) begin
            if ((sub_opt_r == trp_pkg::OPT_MCCP1 || sub_opt_r == trp_pkg::OPT_MCCP2) &&
                comp_r != 2'd0) begin
              lst[0] = mk(trp_pkg::CH_EVENT, 8'd0, trp_pkg::EV_COMPRESS); ln = 6'd1;
            end
            if (sub_opt_r == trp_pkg::OPT_ZMP) begin
              lst[0] = mk(trp_pkg::CH_EVENT, 8'd0, trp_pkg::EV_ZMP_MSG); ln = 6'd1;
            end
            if (sub_opt_r == trp_pkg::OPT_TTYPE) begin
              lst[0] = mk(trp_pkg::CH_EVENT, 8'd0, trp_pkg::EV_TTYPE); ln = 6'd1;
            end
          end
          sub_opt_nxt = '0; sub_sec_nxt = '0; sub_len_nxt = '0; pst_nxt = P_NORMAL;
        end
      end
      P_ANSI: begin
        if (alpha) begin
          esc_cnt_nxt = '0; pst_nxt = P_NORMAL;
          play = (b == trp_pkg::CH_M) || (b == trp_pkg::CH_Z);
        end else if (esc_cnt_r >= 6'(trp_pkg::EscDepth)) begin
          esc_cnt_nxt = '0; pst_nxt = P_NORMAL;
          lst[0] = mk(trp_pkg::CH_EVENT, 8'd0, trp_pkg::EV_OVERFLOW); ln = 6'd1;
        end else begin
          ram_we = acc; esc_cnt_nxt = esc_cnt_r + 6'd1;
        end
      end
      default: begin
        pst_nxt = P_NORMAL;
        if (b == trp_pkg::B_IAC) pst_nxt = P_IAC;
        else if (b == trp_pkg::B_ESC) begin
          ram_we = acc; ram_wa = '0; esc_cnt_nxt = 6'd1; pst_nxt = P_ANSI;
        end else if (b != 8'd0 && b != trp_pkg::B_CR) begin
          lst[0] = mk(trp_pkg::CH_USER, b, trp_pkg::EV_NONE); ln = 6'd1;
        end
      end
    endcase
  end

  // Escape playback reads one buffered byte ahead
  logic rd_more;
  assign rd_more = (rd_i_r + 6'd1) < esc_cnt_r;
  assign ram_ra = (mode_r == M_ESCRD && !(rd_pend_r && !free)) ?
                  rd_i_r[trp_pkg::EscAw-1:0] + trp_pkg::EscAw'(rd_more) :
                  rd_i_r[trp_pkg::EscAw-1:0];

  // Output push selection
  always_comb begin
    push = 1'b0; push_word = scr_r[scr_i_r];
    if (mode_r == M_SCRIPT) begin
      push = free;
      push_word.last = (scr_i_r == scr_n_r);
    end else if (mode_r == M_ESCRD) begin
      push = free && rd_pend_r;
      push_word = mk(trp_pkg::CH_USER, rd_i_r == esc_cnt_r ? fin_r : ram_q,
                     trp_pkg::EV_NONE);
      push_word.last = (rd_i_r == esc_cnt_r);
    end else if (acc && ln == 1) begin
      push = 1'b1; push_word = lst[0]; push_word.last = 1'b1;
    end
  end

  // State, configuration and burst sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pst_r <= P_NORMAL; mode_r <= M_IDLE; esc_cnt_r <= '0;
      sub_opt_r <= '0; sub_sec_r <= '0; sub_len_r <= '0; comp_r <= '0;
      sound_r <= 1'b0; echo_r <= 1'b0; naws_r <= 1'b0;
      win_w_r <= 16'd80; win_h_r <= 16'd24;
      scr_i_r <= '0; scr_n_r <= '0; rd_i_r <= '0; rd_pend_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == trp_pkg::CFG_WIDTH) win_w_r <= cfg_data;
      if (cfg_valid && cfg_index == trp_pkg::CFG_HEIGHT) win_h_r <= cfg_data;
      case (mode_r)
        M_IDLE: begin
          if (acc) begin
            pst_r <= pst_nxt; sub_opt_r <= sub_opt_nxt; sub_sec_r <= sub_sec_nxt;
            sub_len_r <= sub_len_nxt; comp_r <= comp_nxt; sound_r <= sound_nxt;
            echo_r <= echo_nxt; naws_r <= naws_nxt;
            esc_cnt_r <= play ? esc_cnt_r : esc_cnt_nxt;
            if (ln > 1) begin
              mode_r <= M_SCRIPT; scr_i_r <= '0;
              scr_n_r <= trp_pkg::ScrAw'(ln - 1'b1);
            end else if (play) begin
              mode_r <= M_ESCRD; rd_i_r <= '0; rd_pend_r <= 1'b1; fin_r <= b;
            end
          end
        end
        M_SCRIPT: begin
          if (free) begin
            scr_i_r <= scr_i_r + 1'b1;
            if (scr_i_r == scr_n_r) mode_r <= M_IDLE;
          end
        end
        M_ESCRD: begin
          if (free) begin
            if (rd_i_r == esc_cnt_r) begin
              // Park the read pointer at the head for the next playback
              mode_r <= M_IDLE; esc_cnt_r <= '0; rd_pend_r <= 1'b0; rd_i_r <= '0;
            end else begin
              rd_i_r <= rd_i_r + 6'd1;
            end
          end
        end
        default: mode_r <= M_IDLE;
      endcase
    end
    if (mode_r == M_IDLE && acc) begin
      for (int k = 0; k < trp_pkg::ScrDepth; k++) scr_r[k] <= lst[k];
    end
  end
endmodule

>>> design/trp_checker.sv
// Port-level checker for the telnet receive parser, bound to the top level.
// Depends on trp_pkg and telnet_receive_parser_top_defines.svh.
`include "telnet_receive_parser_top_defines.svh"
module trp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  // A stalled word holds
  `TRP_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // Event words carry a zero byte
  `TRP_ASSERT_IMPL(a_evzero, out_tvalid && out_tuser == trp_pkg::CH_EVENT, out_tdata[7:0] == 8'd0)
  // Data and reply words carry no event
  `TRP_ASSERT_IMPL(a_noev, out_tvalid && out_tuser != trp_pkg::CH_EVENT, out_tdata[11:8] == trp_pkg::EV_NONE)
  // Events only close a run
  `TRP_ASSERT_IMPL(a_evlast, out_tvalid && out_tuser == trp_pkg::CH_EVENT, out_tlast)
endmodule

bind telnet_receive_parser_top trp_checker u_trp_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast)
);

>>> tb/telnet_receive_parser_top_tb.sv
// Testbench for the telnet receive parser: drives received bytes on the input
// stream, predicts user, reply and event words and checks them in order.
// Depends on trp_pkg and the telnet_receive_parser_top RTL.
module telnet_receive_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 60;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  telnet_receive_parser_top uut (.*);

  typedef enum logic [3:0] {
    PS_NORMAL, PS_IAC, PS_WILL, PS_WONT, PS_DO, PS_DONT, PS_SB, PS_SBIAC, PS_ANSI
  } parse_e;

  // Predictor state
  parse_e      ps;
  logic [7:0]  esc_buf [trp_pkg::EscDepth];
  int unsigned esc_cnt;
  logic [7:0]  sub_opt, sub_sec;
  int unsigned sub_len;
  logic [1:0]  comp_ver;
  logic        sound_on, echo_on, naws_sent;
  logic [15:0] win_w, win_h;

  trp_pkg::res_t pending_words [$];
  trp_pkg::res_t step_words [$];
  int   errors, bytes_sent, words_seen, events_seen;
  int   cyc = 0;
  int   send_idle_pct, recv_stall_pct;
  logic hold_off;

  // Clock, cycle count and timeout
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("timeout after %0d cycles", cyc);
      $display("FAIL");
      $finish;
    end
  end

  function automatic void put_word(logic [1:0] ch, logic [7:0] b, logic [3:0] ev);
    trp_pkg::res_t w;
    w.chan = ch; w.data = b; w.ev = ev; w.last = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void put_reply(logic [7:0] b);
    put_word(trp_pkg::CH_REPLY, b, trp_pkg::EV_NONE);
    if (b == trp_pkg::B_IAC) put_word(trp_pkg::CH_REPLY, b, trp_pkg::EV_NONE);
  endfunction

  function automatic void put_cmd(logic [7:0] cmd, logic [7:0] opt);
    put_word(trp_pkg::CH_REPLY, trp_pkg::B_IAC, trp_pkg::EV_NONE);
    put_reply(cmd);
    put_reply(opt);
  endfunction

  function automatic void put_event(logic [3:0] ev);
    put_word(trp_pkg::CH_EVENT, 8'd0, ev);
  endfunction

  function automatic void sub_keep(logic [7:0] b);
    if (sub_len >= trp_pkg::SubMax) begin
      put_event(trp_pkg::EV_OVERFLOW);
      return;
    end
    if (sub_len == 0) sub_opt = b;
    else if (sub_len == 1) sub_sec = b;
    sub_len++;
  endfunction

  function automatic void sub_close();
    if (sub_len != 0) begin
      if ((sub_opt == trp_pkg::OPT_MCCP1 || sub_opt == trp_pkg::OPT_MCCP2) && comp_ver != 0)
        put_event(trp_pkg::EV_COMPRESS);
      if (sub_opt == trp_pkg::OPT_ZMP) put_event(trp_pkg::EV_ZMP_MSG);
      if (sub_opt == trp_pkg::OPT_TTYPE) put_event(trp_pkg::EV_TTYPE);
    end
    sub_opt = 0; sub_sec = 0; sub_len = 0;
    ps = PS_NORMAL;
  endfunction

  function automatic void answer_will(logic [7:0] b);
    case (b)
      trp_pkg::OPT_MCCP2: if (comp_ver == 0) begin
        put_cmd(trp_pkg::B_DO, b); comp_ver = 2; put_event(trp_pkg::EV_MCCP2);
      end
      trp_pkg::OPT_MCCP1: if (comp_ver == 0) begin
        put_cmd(trp_pkg::B_DO, b); comp_ver = 1; put_event(trp_pkg::EV_MCCP1);
      end
      trp_pkg::OPT_EOR: begin put_cmd(trp_pkg::B_DO, b); put_event(trp_pkg::EV_EOR); end
      trp_pkg::OPT_MSP: if (!sound_on) begin
        put_cmd(trp_pkg::B_DO, b); sound_on = 1; put_event(trp_pkg::EV_MSP);
      end
      trp_pkg::OPT_MXP: begin put_cmd(trp_pkg::B_DO, b); put_event(trp_pkg::EV_MXP); end
      trp_pkg::OPT_ZMP: begin put_cmd(trp_pkg::B_DO, b); put_event(trp_pkg::EV_ZMP); end
      trp_pkg::OPT_ECHO: begin
        put_cmd(trp_pkg::B_DO, b); echo_on = 1; put_event(trp_pkg::EV_ECHO_ON);
      end
      default: put_cmd(trp_pkg::B_DONT, b);
    endcase
  endfunction

  function automatic void answer_do(logic [7:0] b);
    if (b == trp_pkg::OPT_NAWS) begin
      if (!naws_sent) begin
        put_cmd(trp_pkg::B_WILL, b);
        naws_sent = 1;
        put_word(trp_pkg::CH_REPLY, trp_pkg::B_IAC, trp_pkg::EV_NONE);
        put_word(trp_pkg::CH_REPLY, trp_pkg::B_SB, trp_pkg::EV_NONE);
        put_word(trp_pkg::CH_REPLY, trp_pkg::OPT_NAWS, trp_pkg::EV_NONE);
        put_reply(win_w[15:8]);
        put_reply(win_w[7:0]);
        put_reply(win_h[15:8]);
        put_reply(win_h[7:0]);
        put_word(trp_pkg::CH_REPLY, trp_pkg::B_IAC, trp_pkg::EV_NONE);
        put_word(trp_pkg::CH_REPLY, trp_pkg::B_SE, trp_pkg::EV_NONE);
        put_event(trp_pkg::EV_NAWS);
      end
    end else if (b == trp_pkg::OPT_MXP) begin
      put_cmd(trp_pkg::B_WILL, b);
      put_event(trp_pkg::EV_MXP);
    end else begin
      put_cmd(trp_pkg::B_WONT, b);
    end
  endfunction

  function automatic void escape_byte(logic [7:0] b);
    logic alpha;
    alpha = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    if (alpha) begin
      if (b == trp_pkg::CH_M || b == trp_pkg::CH_Z) begin
        for (int j = 0; j < esc_cnt && j < trp_pkg::EscDepth; j++)
          put_word(trp_pkg::CH_USER, esc_buf[j], trp_pkg::EV_NONE);
        put_word(trp_pkg::CH_USER, b, trp_pkg::EV_NONE);
      end
      esc_cnt = 0;
      ps = PS_NORMAL;
    end else if (esc_cnt >= trp_pkg::EscDepth) begin
      esc_cnt = 0;
      ps = PS_NORMAL;
      put_event(trp_pkg::EV_OVERFLOW);
    end else begin
      esc_buf[esc_cnt] = b;
      esc_cnt++;
    end
  endfunction

  // Advance the predictor by one received byte and queue its words
  function automatic void parse_rx_byte(logic [7:0] b);
    step_words.delete();
    case (ps)
      PS_IAC: begin
        ps = PS_NORMAL;
        if (b == trp_pkg::B_IAC) put_word(trp_pkg::CH_USER, trp_pkg::B_IAC, trp_pkg::EV_NONE);
        else if (b == trp_pkg::B_WILL) ps = PS_WILL;
        else if (b == trp_pkg::B_WONT) ps = PS_WONT;
        else if (b == trp_pkg::B_DO) ps = PS_DO;
        else if (b == trp_pkg::B_DONT) ps = PS_DONT;
        else if (b == trp_pkg::B_SB) ps = PS_SB;
      end
      PS_WILL: begin ps = PS_NORMAL; answer_will(b); end
      PS_WONT: begin
        ps = PS_NORMAL;
        if (b == trp_pkg::OPT_ECHO) begin
          put_cmd(trp_pkg::B_DONT, b); echo_on = 0; put_event(trp_pkg::EV_ECHO_OFF);
        end
      end
      PS_DO: begin ps = PS_NORMAL; answer_do(b); end
      PS_DONT: ps = PS_NORMAL;
      PS_SB: begin
        if (b == trp_pkg::B_IAC) ps = PS_SBIAC;
        else if (b == trp_pkg::B_SE && sub_len == 2 && sub_opt == trp_pkg::OPT_MCCP1 &&
                 sub_sec == trp_pkg::B_WILL)
          sub_close();
        else sub_keep(b);
      end
      PS_SBIAC: begin
        if (b == trp_pkg::B_SE) sub_close();
        else begin sub_keep(trp_pkg::B_IAC); ps = PS_SB; end
      end
      PS_ANSI: escape_byte(b);
      default: begin
        ps = PS_NORMAL;
        if (b == trp_pkg::B_IAC) ps = PS_IAC;
        else if (b == trp_pkg::B_ESC) begin
          esc_buf[0] = b; esc_cnt = 1; ps = PS_ANSI;
        end else if (b != 8'd0 && b != trp_pkg::B_CR)
          put_word(trp_pkg::CH_USER, b, trp_pkg::EV_NONE);
      end
    endcase
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
    foreach (step_words[i]) pending_words.push_back(step_words[i]);
  endfunction

  // Random source side with idling; valid stays up between back-to-back words
  task automatic send_byte(logic [7:0] b);
    if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99, 0) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  // Drop valid and wait for every expected word
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write both window registers back to back
  task automatic write_window(logic [15:0] w_val, logic [15:0] h_val);
    cfg_valid <= 1'b1;
    cfg_index <= trp_pkg::CFG_WIDTH;
    cfg_data <= w_val;
    do @(posedge clk); while (!cfg_ready);
    win_w = w_val;
    cfg_index <= trp_pkg::CFG_HEIGHT;
    cfg_data <= h_val;
    do @(posedge clk); while (!cfg_ready);
    win_h = h_val;
    cfg_valid <= 1'b0;
  endtask

  // Sink side: random stalls plus the long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !hold_off &&
        !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
  end

  // Check each accepted word against the oldest expectation
  always @(posedge clk) begin
    trp_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("unexpected word data=%0d chan=%0d", out_tdata[7:0], out_tuser);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (want.chan == trp_pkg::CH_EVENT) events_seen++;
        if (out_tuser !== want.chan) begin
          $error("out_channel: expected %0d, got %0d", want.chan, out_tuser); errors++;
        end
        if (out_tdata[7:0] !== want.data) begin
          $error("out_byte: expected %0d, got %0d", want.data, out_tdata[7:0]); errors++;
        end
        if (out_tdata[11:8] !== want.ev) begin
          $error("event_code: expected %0d, got %0d", want.ev, out_tdata[11:8]); errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, out_tlast); errors++;
        end
      end
    end
  end

  // Directed table: a few rows carry the words expected at a glance
  typedef struct {
    logic [7:0]    b;
    int            nexp;
    trp_pkg::res_t w0;
  } dir_row_t;

  task automatic send_list(logic [7:0] s [$]);
    foreach (s[i]) send_byte(s[i]);
  endtask

  // Random byte biased toward telnet structure
  function automatic logic [7:0] pick_option();
    logic [7:0] opts [10] = '{trp_pkg::OPT_ECHO, trp_pkg::OPT_TTYPE, trp_pkg::OPT_EOR,
                              trp_pkg::OPT_NAWS, trp_pkg::OPT_MCCP1, trp_pkg::OPT_MCCP2,
                              trp_pkg::OPT_MSP, trp_pkg::OPT_MXP, trp_pkg::OPT_ZMP, 8'd0};
    int k;
    k = $urandom_range(10, 0);
    return (k == 10) ? 8'($urandom) : opts[k];
  endfunction

  task automatic random_burst();
    logic [7:0] s [$];
    int kind, n;
    logic [7:0] cmds [4] = '{trp_pkg::B_WILL, trp_pkg::B_WONT, trp_pkg::B_DO, trp_pkg::B_DONT};
    kind = $urandom_range(9, 0);
    case (kind)
      0, 1: s = '{trp_pkg::B_IAC, cmds[$urandom_range(3, 0)], pick_option()};
      2: begin
        s = '{trp_pkg::B_IAC, trp_pkg::B_SB, pick_option()};
        n = $urandom_range(4, 0);
        repeat (n) s.push_back(($urandom_range(3, 0) == 0) ? trp_pkg::B_IAC : 8'($urandom));
        s.push_back(trp_pkg::B_IAC);
        s.push_back(trp_pkg::B_SE);
      end
      3: begin
        s = '{trp_pkg::B_ESC};
        n = ($urandom_range(9, 0) == 0) ? 33 : $urandom_range(6, 0);
        repeat (n) s.push_back(8'($urandom_range(63, 32)));
        s.push_back(($urandom_range(2, 0) == 0) ? "k" :
                    (($urandom & 1) ? trp_pkg::CH_M : trp_pkg::CH_Z));
      end
      4: s = '{trp_pkg::B_IAC, trp_pkg::B_IAC};
      5: s = '{trp_pkg::B_IAC, trp_pkg::B_SB, trp_pkg::OPT_MCCP1, trp_pkg::B_WILL,
               trp_pkg::B_SE};
      default: begin
        n = $urandom_range(4, 1);
        repeat (n) s.push_back(8'($urandom));
      end
    endcase
    send_list(s);
  endtask

  initial begin
    dir_row_t rows [$];
    int before_cnt;
    trp_pkg::res_t w;

    in_tvalid = 0; in_tdata = 0; cfg_valid = 0; cfg_index = trp_pkg::CFG_WIDTH;
    cfg_data = 0;
    rst_n = 0; hold_off = 0; errors = 0; bytes_sent = 0;
    words_seen = 0; events_seen = 0; send_idle_pct = 0; recv_stall_pct = 0;
    ps = PS_NORMAL; esc_cnt = 0; sub_opt = 0; sub_sec = 0; sub_len = 0;
    comp_ver = 0; sound_on = 0; echo_on = 0; naws_sent = 0; win_w = 16'd80; win_h = 16'd24;
    foreach (esc_buf[i]) esc_buf[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: plain extremes, drops, doubled IAC, echo, NAWS at reset size
    w.chan = trp_pkg::CH_USER; w.ev = trp_pkg::EV_NONE; w.last = 1;
    w.data = 8'd1;   rows.push_back('{8'd1, 1, w});
    w.data = 8'd254; rows.push_back('{8'd254, 1, w});
    rows.push_back('{8'd0, 0, w});
    rows.push_back('{trp_pkg::B_CR, 0, w});
    rows.push_back('{trp_pkg::B_IAC, 0, w});
    w.data = trp_pkg::B_IAC;  rows.push_back('{trp_pkg::B_IAC, 1, w});
    foreach (rows[i]) begin
      send_byte(rows[i].b);
      if (step_words.size() != rows[i].nexp) begin
        $error("word count: expected %0d, got %0d", rows[i].nexp, step_words.size());
        errors++;
      end else if (rows[i].nexp == 1 && step_words[0] != rows[i].w0) begin
        $error("directed word: expected %p, got %p", rows[i].w0, step_words[0]);
        errors++;
      end
    end
    send_list('{trp_pkg::B_IAC, trp_pkg::B_DO, trp_pkg::OPT_NAWS});
    send_list('{trp_pkg::B_IAC, trp_pkg::B_WILL, trp_pkg::OPT_ECHO,
                trp_pkg::B_IAC, trp_pkg::B_WONT, trp_pkg::OPT_ECHO});
    send_list('{trp_pkg::B_IAC, trp_pkg::B_WILL, trp_pkg::OPT_MCCP1, trp_pkg::B_IAC,
                trp_pkg::B_SB, trp_pkg::OPT_MCCP1, trp_pkg::B_WILL, trp_pkg::B_SE});
    send_list('{trp_pkg::B_ESC, "[", "1", trp_pkg::CH_M, trp_pkg::B_ESC, "[", "q"});
    wait_drained();

    // Extremes of the window size; NAWS was answered above, so no size report follows
    write_window(16'hffff, 16'h0000);
    send_list('{trp_pkg::B_IAC, trp_pkg::B_WILL, trp_pkg::OPT_MSP, trp_pkg::B_IAC,
                trp_pkg::B_WILL, trp_pkg::OPT_EOR, trp_pkg::B_IAC, trp_pkg::B_DO,
                trp_pkg::OPT_MXP});
    send_list('{trp_pkg::B_IAC, trp_pkg::B_DONT, 8'd5, trp_pkg::B_IAC, trp_pkg::B_SB,
                trp_pkg::OPT_ZMP, 8'd1, trp_pkg::B_IAC, trp_pkg::B_IAC, trp_pkg::B_IAC,
                trp_pkg::B_SE});
    send_list('{trp_pkg::B_IAC, trp_pkg::B_SB, trp_pkg::OPT_TTYPE, 8'd1, trp_pkg::B_IAC,
                trp_pkg::B_SE, trp_pkg::B_IAC, 8'd7});

    // Random phases with several idle profiles and window sizes
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      write_window((phase == 1) ? 16'hff00 : 16'($urandom),
                   (phase == 2) ? 16'h00ff : 16'($urandom));
      send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 33 : 81) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 33 : 81) : 0;
      before_cnt = bytes_sent;
      while (bytes_sent - before_cnt < 50) random_burst();
    end

    // Long receiver hold-off while the source keeps offering bytes
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      repeat (10) send_list('{trp_pkg::B_ESC, "1", trp_pkg::CH_M, trp_pkg::B_IAC,
                              trp_pkg::B_DO, 8'd3});
    join

    wait_drained();
    $display("sent %0d bytes, checked %0d words including %0d events",
             bytes_sent, words_seen, events_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+design
design/trp_pkg.sv
design/trp_esc_ram.sv
design/trp_out_reg.sv
design/telnet_receive_parser_top.sv
design/trp_checker.sv
tb/telnet_receive_parser_top_tb.sv
